// ===== rtl/svl_pkg.sv =====
// ----------------------------------------------------------------------------
// svl_pkg
// Shared types and codes for the sorted value list: operation and status
// codes, the controller command bundle and the datapath status bundle.
// ----------------------------------------------------------------------------
package svl_pkg;

  // width of the value and entry fields on the ports
  localparam int unsigned FieldW = 16;

  // operation codes carried by a transaction on the input channel
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load;        // capture the input value
    logic    exec;        // run insert, delete or empty dump, write one result
    logic    dump_start;  // load the dump counter from the fill count
    logic    emit;        // emit the head entry and rotate the list
    opcode_e op;          // operation of the current transaction
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic empty;      // list holds no entries
    logic dump_last;  // next emitted entry is the final one
  } stat_t;

endpackage

// ===== rtl/svl_ctrl.sv =====
// ----------------------------------------------------------------------------
// svl_ctrl
// Controller for the sorted value list: takes one transaction at a time,
// sequences execution and the entry-by-entry dump.
// ----------------------------------------------------------------------------
module svl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  svl_pkg::stat_t    stat_i,
  output svl_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e           state_q, state_d;
  svl_pkg::opcode_e op_q, op_d;

  logic in_accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // next state and command decode
  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    cmd_o.load       = 1'b0;
    cmd_o.exec       = 1'b0;
    cmd_o.dump_start = 1'b0;
    cmd_o.emit       = 1'b0;
    cmd_o.op         = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (opcode_i) inside
            svl_pkg::OP_INSERT, svl_pkg::OP_DELETE, svl_pkg::OP_DUMP: begin
              cmd_o.load = 1'b1;
              op_d       = svl_pkg::opcode_e'(opcode_i);
              state_d    = S_EXEC;
            end
            default: begin
              // unused code: transaction dropped without a result
            end
          endcase
        end
      end
      S_EXEC: begin
        if (op_q == svl_pkg::OP_DUMP && !stat_i.empty) begin
          cmd_o.dump_start = 1'b1;
          state_d          = S_DUMP;
        end else if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= svl_pkg::OP_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // state stays one-hot
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("svl_ctrl: state not one-hot");

  // a result is only written into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit || cmd_o.exec) |-> stat_i.out_free)
    else $error("svl_ctrl: result written into busy output register");

  // dump never runs on an empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !stat_i.empty)
    else $error("svl_ctrl: dump running on empty list");

endmodule

// ===== rtl/svl_dpath.sv =====
// ----------------------------------------------------------------------------
// svl_dpath
// Datapath for the sorted value list: a row of compare-and-shift cells that
// holds the entries in ascending order, the fill count and the output
// register.
// ----------------------------------------------------------------------------
module svl_dpath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  svl_pkg::cmd_t               cmd_i,
  output svl_pkg::stat_t              stat_o,
  input  logic [svl_pkg::FieldW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [svl_pkg::FieldW-1:0]  entry_o,
  output logic                        last_o
);

  localparam int unsigned SW = (VALUE_BITS < svl_pkg::FieldW) ? VALUE_BITS
                                                              : svl_pkg::FieldW;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [SW-1:0] e_q [DEPTH];
  logic [SW-1:0] e_d [DEPTH];
  logic [SW-1:0] value_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] dump_left_q, dump_left_d;

  logic [DEPTH-1:0] valid, ge, eq, stop, stop_prev;

  logic full, found, do_ins, do_del;

  logic                        out_valid_q, out_valid_d;
  svl_pkg::status_e            status_q, status_d;
  logic [svl_pkg::FieldW-1:0]  entry_q, entry_d;
  logic                        last_q, last_d;

  assign full   = (count_q == CW'(DEPTH));
  assign found  = |eq;
  assign do_ins = cmd_i.exec && (cmd_i.op == svl_pkg::OP_INSERT) && !full;
  assign do_del = cmd_i.exec && (cmd_i.op == svl_pkg::OP_DELETE) && found;

  // per-cell compare and next entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SW-1:0] e_prev, e_next;

    if (i == 0) begin : g_head
      assign e_prev       = value_q;
      assign stop_prev[i] = 1'b0;
    end else begin : g_body
      assign e_prev       = e_q[i-1];
      assign stop_prev[i] = stop[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign e_next = e_q[0];
    end else begin : g_mid
      assign e_next = e_q[i+1];
    end

    assign valid[i] = (CW'(i) < count_q);
    assign ge[i]    = valid[i] && !(value_q > e_q[i]);
    assign eq[i]    = valid[i] && (e_q[i] == value_q);
    assign stop[i]  = !valid[i] || ge[i];

    always_comb begin
      e_d[i] = e_q[i];
      if (do_ins) begin
        // cells from the insert point on move up by one
        if (stop[i]) begin
          e_d[i] = stop_prev[i] ? e_prev : value_q;
        end
      end else if (do_del) begin
        // cells from the first equal entry on move down by one
        if (ge[i]) begin
          e_d[i] = e_next;
        end
      end else if (cmd_i.emit) begin
        // rotate the filled part so the next entry reaches the head
        if (CW'(i) == CW'(count_q - 1'b1)) begin
          e_d[i] = e_q[0];
        end else begin
          e_d[i] = e_next;
        end
      end
    end
  end

  // entry cells and captured value
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DEPTH; k++) begin
      e_q[k] <= e_d[k];
    end
    if (cmd_i.load) begin
      value_q <= value_i[SW-1:0];
    end
  end

  // fill count and dump counter
  always_comb begin
    count_d     = count_q;
    dump_left_d = dump_left_q;
    if (do_ins) begin
      count_d = CW'(count_q + 1'b1);
    end else if (do_del) begin
      count_d = CW'(count_q - 1'b1);
    end
    if (cmd_i.dump_start) begin
      dump_left_d = count_q;
    end else if (cmd_i.emit) begin
      dump_left_d = CW'(dump_left_q - 1'b1);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    entry_d     = entry_q;
    last_d      = last_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      entry_d     = '0;
      last_d      = 1'b1;
      unique case (cmd_i.op)
        svl_pkg::OP_INSERT: status_d = full ? svl_pkg::ST_FULL : svl_pkg::ST_OK;
        svl_pkg::OP_DELETE: status_d = found ? svl_pkg::ST_OK : svl_pkg::ST_NOT_FOUND;
        svl_pkg::OP_DUMP:   status_d = svl_pkg::ST_EMPTY;
        default:            status_d = svl_pkg::ST_OK;
      endcase
    end else if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      status_d    = svl_pkg::ST_OK;
      entry_d     = svl_pkg::FieldW'(e_q[0]);
      last_d      = (dump_left_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dump_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dump_left_q <= dump_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.dump_last = (dump_left_q == CW'(1));

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign entry_o     = entry_q;
  assign last_o      = last_q;

  // fill count stays within the cell row
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("svl_dpath: fill count beyond depth");

  // an accepted insert grows the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("svl_dpath: insert did not grow the list");

  // an emitted entry shows up as an ok result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q && status_q == svl_pkg::ST_OK)
    else $error("svl_dpath: dump entry not presented");

endmodule

// ===== rtl/sorted_value_list_top.sv =====
// ----------------------------------------------------------------------------
// sorted_value_list_top
// Bounded list of unsigned values kept in ascending order, with insert,
// delete-first-equal and in-order dump operations.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. Insert and delete capture the value
// on acceptance, then every cell compares against it and shifts in parallel
// as the result is written into the output register. A dump emits its entries
// one entry a cycle when the output is free, set by the rotation of the cell
// row through the head cell; an empty dump gives one empty result. A stalled
// output holds the sequence back. The final result of each transaction has
// last set, and the next transaction may be accepted while it still waits on
// the output. Opcode 3 is accepted and dropped with no result.
// ----------------------------------------------------------------------------
module sorted_value_list_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] entry_o,
  output logic        last_o
);

  svl_pkg::cmd_t  cmd;
  svl_pkg::stat_t stat;

  // sequencing
  svl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // cell row, count and output register
  svl_dpath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .entry_o     (entry_o),
    .last_o      (last_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted value list. Drives insert, delete and
// dump transactions with random input idle and output stall, predicts every
// result in a scoreboard and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned ListDepth     = 16;
  localparam int unsigned IdlePct       = 17;
  localparam int unsigned RandomItems   = 225;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 24;
  localparam int unsigned ReportMax     = 10;
  localparam logic [1:0]  OpUnused      = 2'd3;

  // one output transaction
  typedef struct packed {
    svl_pkg::status_e status;
    logic [15:0]      entry;
    logic             last;
  } list_result_t;

  // ordered list model plus the queue of results still owed by the block
  class list_scoreboard;
    logic [15:0]  stored[$];
    list_result_t awaited[$];
    int unsigned  errors;

    function void push(svl_pkg::status_e st, logic [15:0] ent, logic lst);
      list_result_t r;
      r.status = st;
      r.entry  = ent;
      r.last   = lst;
      awaited.push_back(r);
    endfunction

    // apply an accepted input transaction and queue what it produces
    function void note_input(logic [1:0] op, logic [15:0] value);
      int unsigned pos;
      pos = 0;
      case (op)
        svl_pkg::OP_INSERT: begin
          if (stored.size() >= ListDepth) begin
            push(svl_pkg::ST_FULL, '0, 1'b1);
          end else begin
            // equal values go ahead of the stored copies
            while (pos < stored.size() && value > stored[pos]) pos++;
            stored.insert(pos, value);
            push(svl_pkg::ST_OK, '0, 1'b1);
          end
        end
        svl_pkg::OP_DELETE: begin
          while (pos < stored.size() && stored[pos] != value) pos++;
          if (pos < stored.size()) begin
            stored.delete(pos);
            push(svl_pkg::ST_OK, '0, 1'b1);
          end else begin
            push(svl_pkg::ST_NOT_FOUND, '0, 1'b1);
          end
        end
        svl_pkg::OP_DUMP: begin
          if (stored.size() == 0) begin
            push(svl_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            foreach (stored[i]) push(svl_pkg::ST_OK, stored[i], i == stored.size() - 1);
          end
        end
        default: begin
          // unused opcode is dropped without a result
        end
      endcase
    endfunction

    // compare an accepted output transaction with the oldest expectation
    function void check_result(logic [1:0] status, logic [15:0] entry, logic last);
      list_result_t exp_r;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("[%0t] result with nothing awaited: status %0d entry %h last %b",
                   $time, status, entry, last);
        return;
      end
      exp_r = awaited.pop_front();
      if (status !== exp_r.status || entry !== exp_r.entry || last !== exp_r.last) begin
        errors++;
        if (errors <= ReportMax)
          $display("[%0t] expected status %0d entry %h last %b, got status %0d entry %h last %b",
                   $time, exp_r.status, exp_r.entry, exp_r.last, status, entry, last);
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i    = svl_pkg::OP_INSERT;
  logic [15:0] value_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] entry_o;
  logic        last_o;

  logic           no_idle      = 1'b0;
  int unsigned    quiet_cycles = 0;
  list_scoreboard sb;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  sorted_value_list_top #(
    .DEPTH      (ListDepth),
    .VALUE_BITS (16)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .entry_o     (entry_o),
    .last_o      (last_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // random output stall, off during the quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < IdlePct);
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) sb.note_input(opcode_i, value_i);
      if (out_fire) sb.check_result(status_o, entry_o, last_o);
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // present one input transaction and hold it until accepted
  task automatic send_item(input logic [1:0] op, input logic [15:0] val);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int unsigned n;
    int unsigned roll;
    logic [1:0]  op;
    logic [15:0] val;
    sb = new();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, duplicates, not found, full list, unused opcode
    send_item(svl_pkg::OP_DUMP, 16'h1234);
    send_item(svl_pkg::OP_DELETE, 16'h0005);
    send_item(svl_pkg::OP_INSERT, 16'hffff);
    send_item(svl_pkg::OP_INSERT, 16'h0000);
    send_item(svl_pkg::OP_INSERT, 16'h0000);
    send_item(svl_pkg::OP_INSERT, 16'h5555);
    send_item(svl_pkg::OP_INSERT, 16'haaaa);
    send_item(svl_pkg::OP_DUMP, 16'hffff);
    // only the earliest zero goes
    send_item(svl_pkg::OP_DELETE, 16'h0000);
    send_item(svl_pkg::OP_DELETE, 16'h1234);
    send_item(OpUnused, 16'hbeef);
    repeat (12) send_item(svl_pkg::OP_INSERT, 16'($urandom_range(0, 65535)));
    // list is full here
    send_item(svl_pkg::OP_INSERT, 16'h7777);
    send_item(svl_pkg::OP_DUMP, 16'h0000);

    // random: alternating fill and drain phases
    for (n = 0; n < RandomItems; n++) begin
      no_idle = (n >= 100 && n < 160);
      if (n == 200) begin
        // hold off until the block has delivered everything owed
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.awaited.size() != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) op = OpUnused;
      else if (roll < 20) op = svl_pkg::OP_DUMP;
      else if ((n / 50) % 2 == 0) op = (roll < 70) ? svl_pkg::OP_INSERT : svl_pkg::OP_DELETE;
      else op = (roll < 40) ? svl_pkg::OP_INSERT : svl_pkg::OP_DELETE;
      // small values give plenty of duplicates
      if ($urandom_range(0, 1)) val = 16'($urandom_range(0, 15));
      else val = 16'($urandom_range(0, 65535));
      if (op == svl_pkg::OP_DELETE && sb.stored.size() > 0 && $urandom_range(0, 3) != 0)
        val = sb.stored[$urandom_range(0, sb.stored.size() - 1)];
      send_item(op, val);
    end

    // drain and let the block settle
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
